@@ hw/rtl/tab_expanding_line_renderer_unit_defines.svh @@
// Assertion macros for the line renderer RTL.
`ifndef TAB_EXPANDING_LINE_RENDERER_UNIT_DEFINES_SVH
`define TAB_EXPANDING_LINE_RENDERER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define TLER_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tler: same-cycle check failed");

// Next-cycle implication, checked on i_clk outside reset.
`define TLER_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tler: next-cycle check failed");

`endif

@@ hw/rtl/tler_pkg.sv @@
// Shared types and character constants for the line renderer.
package tler_pkg;

    // Width of a run count; covers tab stops up to 31.
    localparam int CNT_W = 5;

    localparam logic [7:0] SCREEN_COLS_RST = 8'd80;

    // Byte-address decode of the register file: word index in paddr[2].
    localparam logic REG_SCREEN_COLS = 1'b0;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_QMARK   = 8'd63;
    localparam logic [7:0] CH_AT      = 8'd64;
    localparam logic [7:0] CH_CARET   = 8'd94;
    localparam logic [7:0] CH_DEL     = 8'd127;

    // One classified input beat: a run of chars, then maybe a newline.
    typedef struct packed {
        logic             caret;  // first char of the run is '^'
        logic [CNT_W-1:0] count;  // chars before the newline
        logic [7:0]       ch;     // char repeated / char after the caret
        logic             eol;    // newline closes the run
    } t_cmd;

endpackage

@@ hw/rtl/tab_expanding_line_renderer_unit.sv @@
// Top level of the tab-expanding line renderer with config registers.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tdata: char_byte, line_start_col; tuser: char_present;
//                                   tlast: end_of_line
//  m_*      out  m_tvalid/m_tready  tdata: out_char; tlast: last_of_run
//  APB      in   psel/penable       reg 0 at 0x0: screen_cols (reset 80)
//
//  A beat that yields N chars (N up to TAB_STOP + 1) gives N output beats;
//  plain bytes flow at one beat per cycle while m_tready is high, set by the back end's single output register.
//  Input is taken whenever the two-entry command queue has room, so the front keeps
//  classifying while the back end expands a tab run or waits on m_tready.
//  Synchronous active-low reset clears the queue and line state; no clearing pass.
module tab_expanding_line_renderer_unit #(
    parameter int TAB_STOP = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_byte, [15:8] line_start_col
    input  logic        s_tuser,   // [0] char_present
    input  logic        s_tlast,   // end_of_line
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,   // last_of_run
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tler_pkg::*;

    logic [7:0] r_screen_cols;
    logic       cfg_wr;
    logic       q_push, q_full, q_valid, q_pop;
    t_cmd       push_cmd, head_cmd;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCREEN_COLS);
    assign prdata = (paddr[2] == REG_SCREEN_COLS) ? {24'd0, r_screen_cols} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_cols <= SCREEN_COLS_RST;
        end else if (cfg_wr) begin
            r_screen_cols <= pwdata[7:0];
        end
    end

    tler_front #(
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_screen_cols (r_screen_cols),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    tler_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    tler_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hw/rtl/tler_front.sv @@
// Front end: accepts input beats, tracks column state, classifies bytes.
module tler_front #(
    parameter int TAB_STOP = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_screen_cols,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [7:0] char_byte, [15:8] line_start_col
    input  logic                s_tuser,   // [0] char_present
    input  logic                s_tlast,   // end_of_line
    input  logic                i_q_full,
    output logic                o_push,
    output tler_pkg::t_cmd      o_cmd
);
    import tler_pkg::*;

    localparam int PW = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;

    // Column-to-tab-phase table, built by counting at elaboration.
    function automatic logic [256*PW-1:0] f_phase_tbl();
        logic [256*PW-1:0] tbl;
        logic [PW-1:0]     ph;
        tbl = '0;
        ph  = '0;
        for (int i = 0; i < 256; i++) begin
            tbl[i*PW +: PW] = ph;
            ph = (ph == PW'(TAB_STOP - 1)) ? '0 : ph + PW'(1);
        end
        return tbl;
    endfunction

    localparam logic [256*PW-1:0] PHASE_TBL = f_phase_tbl();

    logic [7:0] r_column,   n_column;
    logic       r_stopped,  n_stopped;
    logic       r_at_start, n_at_start;

    logic             accept;
    logic [7:0]       byte_in, start_col, col0, room;
    logic             present, stp0;
    logic [PW-1:0]    phase;
    logic [CNT_W-1:0] run_full, run;
    logic [8:0]       col_sum;
    logic [CNT_W-1:0] n_chars;
    logic             caret_fit, is_ctrl;
    t_cmd             cmd;

    assign s_tready  = !i_q_full;
    assign accept    = s_tvalid && s_tready;
    assign byte_in   = s_tdata[7:0];
    assign start_col = s_tdata[15:8];
    assign present   = s_tuser;

    // Column and stop flag as seen by this beat
    always_comb begin
        col0  = r_at_start ? start_col : r_column;
        stp0  = (r_at_start ? 1'b0 : r_stopped) || (col0 >= i_screen_cols);
        room  = i_screen_cols - col0;
        phase = PHASE_TBL[col0*PW +: PW];
        run_full = CNT_W'(TAB_STOP) - CNT_W'(phase);
        run   = ({3'b000, run_full} > room) ? room[CNT_W-1:0] : run_full;
        caret_fit = ({1'b0, col0} + 9'd2) <= {1'b0, i_screen_cols};
        is_ctrl   = (byte_in < CH_SPACE) || (byte_in == CH_DEL);
    end

    // Classify the byte, advance the column
    always_comb begin
        n_chars   = '0;
        col_sum   = {1'b0, col0};
        n_stopped = stp0;
        cmd.caret = 1'b0;
        cmd.ch    = byte_in;
        if (present && !stp0) begin
            priority if (byte_in == CH_NUL) begin
                n_stopped = 1'b1;
            end else if (byte_in == CH_TAB) begin
                n_chars = run;
                cmd.ch  = CH_SPACE;
                col_sum = {1'b0, col0} + {4'b0000, run};
            end else if (is_ctrl) begin
                if (caret_fit) begin
                    n_chars   = CNT_W'(2);
                    cmd.caret = 1'b1;
                    cmd.ch    = (byte_in == CH_DEL) ? CH_QMARK : (CH_AT + byte_in);
                    col_sum   = {1'b0, col0} + 9'd2;
                end else begin
                    n_stopped = 1'b1;
                end
            end else begin
                n_chars = CNT_W'(1);
                col_sum = {1'b0, col0} + 9'd1;
            end
            if (col_sum[7:0] >= i_screen_cols) begin
                n_stopped = 1'b1;
            end
        end
        n_column   = col_sum[7:0];
        n_at_start = 1'b0;
        if (s_tlast) begin
            n_at_start = 1'b1;
            n_stopped  = 1'b0;
        end
        cmd.count = n_chars;
        cmd.eol   = s_tlast;
    end

    assign o_push = accept && ((n_chars != '0) || s_tlast);
    assign o_cmd  = cmd;

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= '0;
            r_stopped  <= 1'b0;
            r_at_start <= 1'b1;
        end else if (accept) begin
            r_column   <= n_column;
            r_stopped  <= n_stopped;
            r_at_start <= n_at_start;
        end
    end

endmodule

@@ hw/rtl/tler_queue.sv @@
// Two-entry command queue between front and back end.
module tler_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tler_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output tler_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import tler_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/tler_back.sv @@
// Back end: expands queued commands into output beats through a register.
module tler_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  tler_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [7:0] out_char
    output logic           m_tlast    // last_of_run
);
    import tler_pkg::*;

    `include "tab_expanding_line_renderer_unit_defines.svh"

    t_cmd             r_cur;
    logic             r_cur_valid, n_cur_valid;
    logic [CNT_W-1:0] r_left,      n_left;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    logic       out_adv, emit, cur_last, pop;
    logic [7:0] beat_char;

    // Current beat of the active command
    always_comb begin
        cur_last = (r_left == '0) || ((r_left == CNT_W'(1)) && !r_cur.eol);
        priority if (r_left == '0) begin
            beat_char = CH_NEWLINE;
        end else if (r_cur.caret && (r_left == CNT_W'(2))) begin
            beat_char = CH_CARET;
        end else begin
            beat_char = r_cur.ch;
        end
    end

    assign out_adv = !r_out_valid || m_tready;
    assign emit    = out_adv && r_cur_valid;
    assign pop     = i_q_valid && (!r_cur_valid || (emit && cur_last));
    assign o_q_pop = pop;

    // Active command bookkeeping
    always_comb begin
        n_cur_valid = r_cur_valid;
        n_left      = r_left;
        if (pop) begin
            n_cur_valid = 1'b1;
            n_left      = i_q_cmd.count;
        end else if (emit) begin
            n_cur_valid = !cur_last;
            n_left      = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_left      <= n_left;
            if (out_adv) begin
                r_out_valid <= r_cur_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_q_cmd;
        end
        if (emit) begin
            r_out_char <= beat_char;
            r_out_last <= cur_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_char;
    assign m_tlast  = r_out_last;

    // Checks
    `TLER_ASSERT_IMP(a_newline_ends_run, m_tvalid && (m_tdata == CH_NEWLINE), m_tlast)
    `TLER_ASSERT_IMP(a_caret_len, r_cur_valid && r_cur.caret, r_left <= CNT_W'(2))
    `TLER_ASSERT_NXT(a_run_no_gap, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule
